/* src/assert_macros.svh */
// assertion macros used by the rtl of the equaliser
// expects a clock named clk and an active-high reset named rst in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define BQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication
`define BQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BQ_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* src/bqeq_pkg.sv */
// shared types, constants and arithmetic helpers of the biquad equaliser
// no dependencies
`default_nettype none

package bqeq_pkg;

  localparam int NCOEF    = 5;   // b0 b1 b2 a1 a2
  localparam int NHIST    = 4;   // x1 x2 y1 y2
  localparam int COEF_W   = 32;
  localparam int HIST_W   = 32;
  localparam int ACC_W    = 38;  // exact sum of five shifted products
  localparam int PROD_W   = 64;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 24;

  // configuration register indexes
  localparam logic CFG_PRE_GAIN = 1'b0;
  localparam logic CFG_STAGES   = 1'b1;

  // item kinds
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_COEF   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_LOAD,
    ST_MAC,
    ST_WB,
    ST_OUT
  } state_t;

  function automatic logic signed [HIST_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = ACC_W'(64'sh7fff_ffff);
    lo = -ACC_W'(64'sh8000_0000);
    if (v > hi) begin
      sat32 = 32'sh7fff_ffff;
    end else if (v < lo) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = v[HIST_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

/* src/bqeq_ram.sv */
// generic single-write, single-read synchronous ram with registered read data
// no dependencies
`default_nettype none

module bqeq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* src/biquad_cascade_equalizer_unit.sv */
// top level of the biquad cascade equaliser: sequencer, shared multiplier,
// coefficient and history memories; uses bqeq_pkg, bqeq_ram, assert_macros.svh
`default_nettype none

// channel   direction  handshake              payload
// s_axis    in         tvalid / tready        tuser = op, tdata = sample / coefficient item
// m_axis    out        tvalid / tready        tuser = clipped, tdata = result sample
// cfg       in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// a sample item runs through the scale and load states, then mac and write-back once per
// section in use, then out: one shared 33x33 multiplier does five products per section,
// each fed by a registered coefficient memory read
// a coefficient write completes in its transfer cycle and the next item is taken at once
// synchronous reset clears control and history valid bits; coefficients stay undefined
// a stalled result holds the sequencer in its last state; the next item is taken as
// soon as the result sits in the output register

module biquad_cascade_equalizer_unit
  import bqeq_pkg::*;
#(
  parameter int MAX_STAGES = 8,
  parameter int CHANNELS   = 2
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // input stream
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // channel[0], sample_in[16:1], coef_stage[19:17], coef_index[22:20],
  // coef_value[54:23], zero[55]
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // op[0]
  input  wire logic                  s_axis_tuser,
  // result stream
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // sample_out[15:0], channel_out[16], zero[23:17]
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  // clipped[0]
  output logic                       m_axis_tuser,
  // configuration writes
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic                  cfg_index,
  input  wire logic [23:0]           cfg_data
);

`include "assert_macros.svh"

  localparam int CDEPTH = CHANNELS * MAX_STAGES * NCOEF;
  localparam int HDEPTH = CHANNELS * MAX_STAGES;
  localparam int CAW    = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;
  localparam int HAW    = (HDEPTH > 1) ? $clog2(HDEPTH) : 1;
  localparam int SW     = $clog2(MAX_STAGES + 1);

  // input fields
  logic                      in_op;
  logic                      in_channel;
  logic signed [15:0]        in_sample;
  logic [2:0]                in_stage;
  logic [2:0]                in_index;
  logic [COEF_W-1:0]         in_value;

  assign in_op      = s_axis_tuser;
  assign in_channel = s_axis_tdata[0];
  assign in_sample  = s_axis_tdata[16:1];
  assign in_stage   = s_axis_tdata[19:17];
  assign in_index   = s_axis_tdata[22:20];
  assign in_value   = s_axis_tdata[54:23];

  // configuration
  logic [23:0] pre_gain;
  logic [3:0]  stages_in_use;
  logic [SW-1:0] n_stages;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pre_gain      <= 24'h10_0000;
      stages_in_use <= 4'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_PRE_GAIN: pre_gain      <= cfg_data;
        CFG_STAGES:   stages_in_use <= cfg_data[3:0];
        default:      ;
      endcase
    end
  end

  // more than MAX_STAGES sections act as MAX_STAGES
  assign n_stages = ({1'b0, stages_in_use} > 5'(MAX_STAGES)) ? SW'(MAX_STAGES)
                                                           : SW'(stages_in_use);

  // sequencer registers
  state_t                    state;
  state_t                    state_next;
  logic [2:0]                kcnt;
  logic [SW-1:0]             stage_cnt;
  logic [CAW-1:0]            coef_addr;
  logic [HAW-1:0]            hist_row;
  logic                      hist_ok;
  logic                      ch_r;
  logic signed [15:0]        sample_r;
  logic signed [HIST_W-1:0]  x_r;
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   last_v;
  logic signed [PROD_W-1:0]  prod;
  logic [(1 << HAW)-1:0]     hist_vld;

  // control outputs of the sequencer
  logic accept;
  logic is_coef_wr;
  logic is_sample;
  logic coef_rd;
  logic hist_rd;
  logic hist_we;
  logic last_stage;
  logic out_load;

  // memories
  logic [CAW-1:0]            coef_waddr;
  logic [COEF_W-1:0]         coef_q;
  logic [HAW-1:0]            hist_raddr;
  logic [HAW-1:0]            coef_row;
  logic [NHIST*HIST_W-1:0]   hist_q;
  logic [NHIST*HIST_W-1:0]   hist_wdata;
  logic                      ch_ok;
  logic                      coef_ok;

  assign ch_ok   = ({31'b0, in_channel} < 32'(CHANNELS));
  assign coef_ok = ch_ok && ({29'b0, in_index} < 32'(NCOEF))
                         && ({29'b0, in_stage} < 32'(MAX_STAGES));

  assign coef_row   = HAW'({31'b0, in_channel} * 32'(MAX_STAGES) + {29'b0, in_stage});
  assign coef_waddr = CAW'(({31'b0, in_channel} * 32'(MAX_STAGES) + {29'b0, in_stage})
                           * 32'(NCOEF) + {29'b0, in_index});

  assign last_stage = (stage_cnt + SW'(1) == n_stages);
  assign hist_raddr = (state == ST_WB) ? HAW'(hist_row + HAW'(1)) : hist_row;

  // history masked by its row valid bit: a cleared row reads as zero
  logic signed [HIST_W-1:0] h0, h1, h2, h3;
  assign h0 = hist_ok ? hist_q[0*HIST_W +: HIST_W] : '0;
  assign h1 = hist_ok ? hist_q[1*HIST_W +: HIST_W] : '0;
  assign h2 = hist_ok ? hist_q[2*HIST_W +: HIST_W] : '0;
  assign h3 = hist_ok ? hist_q[3*HIST_W +: HIST_W] : '0;

  bqeq_ram #(
    .WIDTH (COEF_W),
    .DEPTH (CDEPTH)
  ) u_coef_ram (
    .clk   (clk),
    .we    (is_coef_wr && coef_ok),
    .waddr (coef_waddr),
    .wdata (in_value),
    .re    (coef_rd),
    .raddr (coef_addr),
    .rdata (coef_q)
  );

  bqeq_ram #(
    .WIDTH (NHIST * HIST_W),
    .DEPTH (HDEPTH)
  ) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_row),
    .wdata (hist_wdata),
    .re    (hist_rd),
    .raddr (hist_raddr),
    .rdata (hist_q)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (is_sample) begin
          state_next = ST_SCALE;
        end
      end
      ST_SCALE: state_next = ST_LOAD;
      ST_LOAD: begin
        state_next = (n_stages == '0) ? ST_OUT : ST_MAC;
      end
      ST_MAC: begin
        if (kcnt == 3'd4) begin
          state_next = ST_WB;
        end
      end
      ST_WB: begin
        state_next = last_stage ? ST_OUT : ST_MAC;
      end
      ST_OUT: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_axis_tready = 1'b0;
    coef_rd       = 1'b0;
    hist_rd       = 1'b0;
    hist_we       = 1'b0;
    out_load      = 1'b0;
    unique case (state)
      ST_IDLE:  s_axis_tready = 1'b1;
      ST_SCALE: ;
      ST_LOAD: begin
        coef_rd = (n_stages != '0);
        hist_rd = (n_stages != '0);
      end
      ST_MAC:   coef_rd = (kcnt != 3'd4);
      ST_WB: begin
        hist_we = 1'b1;
        coef_rd = !last_stage;
        hist_rd = !last_stage;
      end
      ST_OUT:   out_load = !m_axis_tvalid || m_axis_tready;
      default:  ;
    endcase
  end

  assign accept     = s_axis_tvalid && s_axis_tready;
  assign is_coef_wr = accept && (in_op == OP_COEF);
  assign is_sample  = accept && (in_op == OP_SAMPLE) && ch_ok;

  // shared multiplier operands
  logic signed [32:0]        mul_a;
  logic signed [32:0]        mul_b;
  logic signed [HIST_W-1:0]  opnd;
  logic signed [ACC_W-1:0]   term;
  logic signed [ACC_W-1:0]   sec_sum;
  logic signed [HIST_W-1:0]  y;

  always_comb begin
    unique case (kcnt)
      3'd0:    opnd = x_r;
      3'd1:    opnd = h0;
      3'd2:    opnd = h1;
      3'd3:    opnd = h2;
      default: opnd = h3;
    endcase
  end

  always_comb begin
    if (state == ST_SCALE) begin
      mul_a = {{17{sample_r[15]}}, sample_r};
      mul_b = {9'b0, pre_gain};
    end else begin
      mul_a = {coef_q[COEF_W-1], coef_q};
      mul_b = {opnd[HIST_W-1], opnd};
    end
  end

  // Q3.28 x Q16.16 product floored back to Q16.16
  assign term    = ACC_W'(prod >>> 28);
  assign sec_sum = acc - term;
  assign y       = sat32(sec_sum);
  // new history: x1 = section input, x2 = old x1, y1 = output, y2 = old y1
  assign hist_wdata = {h2, y, h0, x_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      hist_vld <= '0;
    end else begin
      state <= state_next;
      if (is_coef_wr && coef_ok) begin
        hist_vld[coef_row] <= 1'b0;
      end
      if (hist_we) begin
        hist_vld[hist_row] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= PROD_W'(mul_a * mul_b);
    if (is_sample) begin
      ch_r      <= in_channel;
      sample_r  <= in_sample;
      stage_cnt <= '0;
      coef_addr <= CAW'({31'b0, in_channel} * 32'(MAX_STAGES * NCOEF));
      hist_row  <= HAW'({31'b0, in_channel} * 32'(MAX_STAGES));
    end
    if (coef_rd) begin
      coef_addr <= coef_addr + CAW'(1);
    end
    if (hist_rd) begin
      hist_ok <= hist_vld[hist_raddr];
    end
    unique case (state)
      ST_LOAD: begin
        last_v <= ACC_W'(prod >>> 4);
        x_r    <= sat32(ACC_W'(prod >>> 4));
        kcnt   <= 3'd0;
      end
      ST_MAC: begin
        kcnt <= kcnt + 3'd1;
        unique case (kcnt)
          3'd0:    acc <= '0;
          3'd4:    acc <= acc - term;
          default: acc <= acc + term;
        endcase
      end
      ST_WB: begin
        last_v    <= sec_sum;
        x_r       <= y;
        kcnt      <= 3'd0;
        stage_cnt <= stage_cnt + SW'(1);
        hist_row  <= HAW'(hist_row + HAW'(1));
      end
      default: ;
    endcase
  end

  // result: truncate toward zero to an integer, then saturate to 16 bits
  logic signed [ACC_W-1:0] rnd_v;
  logic signed [ACC_W-17:0] q_v;
  logic                     q_hi;
  logic                     q_lo;
  logic signed [15:0]       q_sat;

  assign rnd_v = last_v + (last_v[ACC_W-1] ? ACC_W'(65535) : ACC_W'(0));
  assign q_v   = rnd_v[ACC_W-1:16];
  assign q_hi  = (q_v > (ACC_W-16)'(32767));
  assign q_lo  = (q_v < -(ACC_W-16)'(32768));
  assign q_sat = q_hi ? 16'sh7fff : (q_lo ? 16'sh8000 : q_v[15:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {7'b0, ch_r, q_sat};
      m_axis_tuser <= q_hi || q_lo;
    end
  end

  // checks
  `BQ_ASSERT_IMP(a_kcnt_range, state == ST_MAC, kcnt <= 3'd4, "mac step counter out of range")
  `BQ_ASSERT_IMP(a_stage_range, state == ST_MAC || state == ST_WB, stage_cnt < n_stages,
                 "section counter past sections in use")
  `BQ_ASSERT_NXT(a_hist_valid_set, state == ST_WB, hist_vld[$past(hist_row)],
                 "history row not marked valid after write-back")
  `BQ_ASSERT_NXT(a_bypass, state == ST_LOAD && n_stages == '0, state == ST_OUT,
                 "zero sections did not bypass to the result")

endmodule

`default_nettype wire
